// ===== rtl/core/rpfa_pkg.sv =====
// Package for the reference-counted page frame allocator core.
// Holds sizes, operation and status codes, and the word and control types.
// No dependencies.
package rpfa_pkg;

    localparam int PAGES = 1024;
    localparam int AW = $clog2(PAGES);
    localparam int CW = AW + 1;

    localparam logic [1:0] FN_ALLOC = 2'd0;
    localparam logic [1:0] FN_FREE  = 2'd1;
    localparam logic [1:0] FN_SHARE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_TOTAL = 2'd1;
    localparam logic [1:0] CFG_RESV  = 2'd2;

    localparam logic [1:0] FIN_BAD     = 2'd0;
    localparam logic [1:0] FIN_NOSPACE = 2'd1;
    localparam logic [1:0] FIN_ALLOC   = 2'd2;
    localparam logic [1:0] FIN_TARGET  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [10:0] page_count;
        logic [20:0] frame_number;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [20:0] result_frame;
        logic [10:0] released_pages;
        logic [7:0]  owners_after;
    } rsp_t;

    typedef struct packed {
        logic       init_clr;
        logic       load;
        logic       scan;
        logic       walk;
        logic       upd;
        logic       fin;
        logic [1:0] fin_kind;
    } ctl_t;

    typedef struct packed {
        logic       init_last;
        logic       bad;
        logic [1:0] func;
        logic       found;
        logic       exhausted;
        logic       walk_last;
        logic       need_clear;
    } sts_t;

endpackage

// ===== rtl/core/rpfa_ctrl.sv =====
// Sequencing state machine of the page frame allocator core.
// Depends on rpfa_pkg; drives the datapath through ctl_t and reads sts_t.
module rpfa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rpfa_pkg::sts_t sts,
    output rpfa_pkg::ctl_t ctl
);
    import rpfa_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_MARK = 3'd4;
    localparam logic [2:0] S_TUPD = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            S_INIT:
            begin
                ctl.init_clr = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.bad)
                begin
                    ctl.fin = 1'b1;
                    ctl.fin_kind = FIN_BAD;
                    state_next = S_IDLE;
                end
                else if (sts.func == FN_ALLOC)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_TUPD;
                end
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.found)
                begin
                    state_next = S_MARK;
                end
                else if (sts.exhausted)
                begin
                    ctl.fin = 1'b1;
                    ctl.fin_kind = FIN_NOSPACE;
                    state_next = S_IDLE;
                end
            end
            S_MARK:
            begin
                ctl.walk = 1'b1;
                if (sts.walk_last)
                begin
                    ctl.fin = 1'b1;
                    ctl.fin_kind = FIN_ALLOC;
                    state_next = S_IDLE;
                end
            end
            S_TUPD:
            begin
                ctl.upd = 1'b1;
                state_next = sts.need_clear ? S_CLR : S_FIN;
            end
            S_CLR:
            begin
                ctl.walk = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                ctl.fin = 1'b1;
                ctl.fin_kind = FIN_TARGET;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

// ===== rtl/core/rpfa_datapath.sv =====
// Datapath of the page frame allocator core: configuration registers,
// owner count and run length memories, scan and walk counters, result word.
// Depends on rpfa_pkg; commanded by rpfa_ctrl.
module rpfa_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  rpfa_pkg::cmd_t cmd,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [19:0]    cfg_data,
    input  rpfa_pkg::ctl_t ctl,
    output rpfa_pkg::sts_t sts,
    output logic           done,
    output rpfa_pkg::rsp_t rsp
);
    import rpfa_pkg::*;

    logic [7:0]  owner_mem [PAGES];
    logic [10:0] run_mem [PAGES];

    logic [19:0] base_reg;
    logic [CW-1:0] total_reg;
    logic [CW-1:0] resv_reg;

    cmd_t        req_reg;
    logic        bad_reg;
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] evl_reg;
    logic        pend_reg, pend_next;
    logic [10:0] run_reg, run_next;
    logic [CW-1:0] head_reg;
    logic [CW-1:0] stop_reg;
    logic [10:0] rel_reg;
    logic [7:0]  own_after_reg;
    logic [7:0]  own_q;
    logic [10:0] rl_q;
    logic        done_reg;
    rsp_t        rsp_reg;

    logic [CW-1:0] eff_total;
    logic [20:0] off;
    logic        bad_in;
    logic [CW-1:0] ptr_inc;
    logic [10:0] run_new;
    logic        issue;
    logic        found;
    logic [CW-1:0] head_calc;
    logic [CW:0] end_raw;
    logic [CW-1:0] end_clip;
    logic [10:0] rel_calc;
    logic        unshared;
    logic [7:0]  upd_val;
    logic [7:0]  own_after_calc;
    logic [AW-1:0] rd_addr;
    logic        own_we;
    logic [AW-1:0] own_waddr;
    logic [7:0]  own_wdata;
    logic        run_we;
    logic [AW-1:0] run_waddr;
    logic [10:0] run_wdata;

    always_comb
    begin
        eff_total = (total_reg > CW'(PAGES)) ? CW'(PAGES) : total_reg;
        off = cmd.frame_number - {1'b0, base_reg};
        case (cmd.func)
            FN_ALLOC: bad_in = (cmd.page_count == '0);
            FN_FREE,
            FN_SHARE: bad_in = (cmd.frame_number < {1'b0, base_reg})
                               || (off >= {10'd0, eff_total})
                               || (off < {10'd0, resv_reg});
            default:  bad_in = 1'b1;
        endcase

        ptr_inc = ptr_reg + CW'(1);
        run_new = (own_q == 8'd0) ? (run_reg + 11'd1) : 11'd0;
        found = pend_reg && (run_new == req_reg.page_count);
        issue = (ptr_reg < eff_total);
        head_calc = evl_reg - req_reg.page_count + CW'(1);

        end_raw = {2'b00, idx_reg} + {1'b0, rl_q};
        end_clip = (end_raw > {1'b0, eff_total}) ? eff_total : end_raw[CW-1:0];
        rel_calc = end_clip - {1'b0, idx_reg};
        unshared = (req_reg.func == FN_FREE) && (own_q <= 8'd1);
        if (req_reg.func == FN_SHARE)
        begin
            upd_val = (own_q == 8'hFF) ? own_q : own_q + 8'd1;
        end
        else
        begin
            upd_val = own_q - 8'd1;
        end
        if (unshared)
        begin
            own_after_calc = (rel_calc != '0) ? 8'd0 : own_q;
        end
        else
        begin
            own_after_calc = upd_val;
        end

        sts.init_last = (ptr_reg == CW'(PAGES - 1));
        sts.bad = bad_reg;
        sts.func = req_reg.func;
        sts.found = found;
        sts.exhausted = !pend_reg && !issue;
        sts.walk_last = (ptr_inc == stop_reg);
        sts.need_clear = unshared && (rel_calc != '0);

        rd_addr = ctl.scan ? ptr_reg[AW-1:0] : idx_reg;

        own_we = ctl.init_clr || ctl.walk || (ctl.upd && !unshared);
        own_waddr = ctl.upd ? idx_reg : ptr_reg[AW-1:0];
        if (ctl.upd)
        begin
            own_wdata = upd_val;
        end
        else if (ctl.walk && (req_reg.func == FN_ALLOC))
        begin
            own_wdata = 8'd1;
        end
        else
        begin
            own_wdata = 8'd0;
        end

        run_we = ctl.init_clr || (ctl.scan && found) || (ctl.upd && unshared);
        if (ctl.scan)
        begin
            run_waddr = head_calc[AW-1:0];
            run_wdata = req_reg.page_count;
        end
        else if (ctl.upd)
        begin
            run_waddr = idx_reg;
            run_wdata = 11'd0;
        end
        else
        begin
            run_waddr = ptr_reg[AW-1:0];
            run_wdata = 11'd0;
        end

        ptr_next = ptr_reg;
        pend_next = pend_reg;
        run_next = run_reg;
        if (ctl.init_clr || ctl.walk)
        begin
            ptr_next = ptr_inc;
        end
        else if (ctl.load)
        begin
            ptr_next = resv_reg;
            pend_next = 1'b0;
            run_next = 11'd0;
        end
        else if (ctl.scan)
        begin
            if (pend_reg)
            begin
                run_next = run_new;
            end
            pend_next = issue;
            if (found)
            begin
                ptr_next = head_calc;
            end
            else if (issue)
            begin
                ptr_next = ptr_inc;
            end
        end
        else if (ctl.upd)
        begin
            ptr_next = {1'b0, idx_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            total_reg <= CW'(PAGES);
            resv_reg <= CW'(1);
            ptr_reg <= '0;
            pend_reg <= 1'b0;
            run_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE:  base_reg <= cfg_data;
                    CFG_TOTAL: total_reg <= cfg_data[CW-1:0];
                    CFG_RESV:  resv_reg <= cfg_data[CW-1:0];
                    default:   ;
                endcase
            end
            ptr_reg <= ptr_next;
            pend_reg <= pend_next;
            run_reg <= run_next;
            done_reg <= ctl.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= cmd;
            bad_reg <= bad_in;
            idx_reg <= off[AW-1:0];
        end
        if (ctl.scan)
        begin
            if (issue)
            begin
                evl_reg <= ptr_reg;
            end
            if (found)
            begin
                head_reg <= head_calc;
                stop_reg <= evl_reg + CW'(1);
            end
        end
        if (ctl.upd)
        begin
            stop_reg <= end_clip;
            rel_reg <= unshared ? rel_calc : 11'd0;
            own_after_reg <= own_after_calc;
        end
        if (ctl.fin)
        begin
            case (ctl.fin_kind)
                FIN_ALLOC:
                begin
                    rsp_reg.status <= ST_OK;
                    rsp_reg.result_frame <= {1'b0, base_reg} + {10'd0, head_reg};
                    rsp_reg.released_pages <= 11'd0;
                    rsp_reg.owners_after <= 8'd1;
                end
                FIN_TARGET:
                begin
                    rsp_reg.status <= ST_OK;
                    rsp_reg.result_frame <= '0;
                    rsp_reg.released_pages <= rel_reg;
                    rsp_reg.owners_after <= own_after_reg;
                end
                FIN_NOSPACE:
                begin
                    rsp_reg.status <= ST_NOSPACE;
                    rsp_reg.result_frame <= '0;
                    rsp_reg.released_pages <= 11'd0;
                    rsp_reg.owners_after <= 8'd0;
                end
                default:
                begin
                    rsp_reg.status <= ST_BAD;
                    rsp_reg.result_frame <= '0;
                    rsp_reg.released_pages <= 11'd0;
                    rsp_reg.owners_after <= 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            owner_mem[own_waddr] <= own_wdata;
        end
        own_q <= owner_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (run_we)
        begin
            run_mem[run_waddr] <= run_wdata;
        end
        rl_q <= run_mem[idx_reg];
    end

    assign done = done_reg;
    assign rsp = rsp_reg;

endmodule

// ===== rtl/core/refcounted_page_frame_allocator_core.sv =====
// Top level of the reference-counted page frame allocator core.
// Depends on rpfa_pkg, rpfa_ctrl and rpfa_datapath.
//
// Channel    Ports                                   Handshake
// command    start, busy, cmd (cmd_t)                taken when start and not busy
// result     done, rsp (rsp_t)                       one-cycle strobe, no backpressure
// config     cfg_valid, cfg_ready, cfg_index, cfg_data  taken when valid and ready
//
// Alloc scans the frames one per cycle through the owner count memory read port,
// then marks the granted pages; free or share update the target frame's owner count,
// then clear the released pages if any, and a rejected word ends after the check.
// One word is processed at a time.
// After reset a clearing pass zeroes both memories with busy high.
// The result strobe is raised for one cycle and cannot be stalled.
module refcounted_page_frame_allocator_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rpfa_pkg::cmd_t cmd,
    output logic           done,
    output rpfa_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [19:0]    cfg_data
);
    import rpfa_pkg::*;

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    rpfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    rpfa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .sts       (sts),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

// ===== tb/refcounted_page_frame_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for refcounted_page_frame_allocator_core. It drives commands and
// register writes and checks every reply against a frame map kept in step with the block.
// Depends on rpfa_pkg and the core RTL.
module refcounted_page_frame_allocator_core_tb;
    import rpfa_pkg::*;

    localparam logic [1:0] FN_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int DRAIN_CYCLES = 2200;
    localparam int SHOWN_ERRORS = 10;

    class frame_ledger;
        logic [7:0]  owners [PAGES];
        logic [10:0] run_len [PAGES];
        logic [19:0] base;
        logic [10:0] total;
        logic [10:0] resv;
        rsp_t        pending_replies [$];
        int          mismatches;
        int          last_head;
        int          n_requests;
        int          n_granted;
        int          n_nospace;
        int          n_bad;
        int          n_released;
        int          peak_owners;

        function new();
            base = '0;
            total = 11'd1024;
            resv = 11'd1;
            foreach (owners[i])
            begin
                owners[i] = '0;
                run_len[i] = '0;
            end
            mismatches = 0;
            last_head = -1;
            n_requests = 0;
            n_granted = 0;
            n_nospace = 0;
            n_bad = 0;
            n_released = 0;
            peak_owners = 0;
        endfunction

        function int span();
            return (int'(total) > PAGES) ? PAGES : int'(total);
        endfunction

        function void write_reg(logic [1:0] idx, logic [19:0] data);
            case (idx)
                CFG_BASE:
                begin
                    base = data;
                end
                CFG_TOTAL:
                begin
                    total = data[10:0];
                end
                CFG_RESV:
                begin
                    resv = data[10:0];
                end
                default:
                begin
                end
            endcase
        endfunction

        function logic [20:0] phys(int idx);
            return 21'(base) + 21'(idx);
        endfunction

        function bit map_frame(logic [20:0] frame, output int idx);
            longint off;
            idx = 0;
            if (frame < base)
                return 1'b0;
            off = longint'(frame) - longint'(base);
            if (off >= span() || off < longint'(resv))
                return 1'b0;
            idx = int'(off);
            return 1'b1;
        endfunction

        // Random frame in the managed range that owns something; heads only if asked.
        function int pick(bit heads_only);
            int first;
            int i;
            first = $urandom_range(0, PAGES - 1);
            for (int k = 0; k < PAGES; k++)
            begin
                i = (first + k) % PAGES;
                if (i >= int'(resv) && i < span() &&
                    (heads_only ? (run_len[i] != 0) : (owners[i] != 0)))
                    return i;
            end
            return -1;
        endfunction

        function int in_range_index();
            if (span() > int'(resv))
                return $urandom_range(int'(resv), span() - 1);
            return -1;
        endfunction

        function void apply_request(cmd_t c);
            rsp_t r;
            int idx;
            int run;
            int head;
            int stop;
            r = '0;
            r.status = ST_BAD;
            last_head = -1;
            n_requests++;
            case (c.func)
                FN_ALLOC:
                begin
                    if (c.page_count != 0)
                    begin
                        r.status = ST_NOSPACE;
                        run = 0;
                        for (int i = int'(resv); i < span(); i++)
                        begin
                            if (owners[i] == 0)
                                run++;
                            else
                                run = 0;
                            if (run == int'(c.page_count))
                            begin
                                head = i + 1 - run;
                                for (int j = head; j <= i; j++)
                                    owners[j] = 8'd1;
                                run_len[head] = c.page_count;
                                r.status = ST_OK;
                                r.result_frame = phys(head);
                                r.owners_after = 8'd1;
                                last_head = head;
                                break;
                            end
                        end
                    end
                end
                FN_FREE:
                begin
                    if (map_frame(c.frame_number, idx))
                    begin
                        r.status = ST_OK;
                        if (owners[idx] > 1)
                            owners[idx] = owners[idx] - 8'd1;
                        else
                        begin
                            stop = idx + int'(run_len[idx]);
                            if (stop > span())
                                stop = span();
                            for (int j = idx; j < stop; j++)
                                owners[j] = '0;
                            r.released_pages = 11'(stop - idx);
                            run_len[idx] = '0;
                        end
                        r.owners_after = owners[idx];
                    end
                end
                FN_SHARE:
                begin
                    if (map_frame(c.frame_number, idx))
                    begin
                        r.status = ST_OK;
                        if (owners[idx] < 8'd255)
                            owners[idx] = owners[idx] + 8'd1;
                        r.owners_after = owners[idx];
                    end
                end
                default:
                begin
                end
            endcase
            if (r.status == ST_OK && c.func == FN_ALLOC)
                n_granted++;
            if (r.status == ST_NOSPACE)
                n_nospace++;
            if (r.status == ST_BAD)
                n_bad++;
            n_released += int'(r.released_pages);
            if (int'(r.owners_after) > peak_owners)
                peak_owners = int'(r.owners_after);
            pending_replies.push_back(r);
        endfunction

        function void check_reply(rsp_t got);
            rsp_t want;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("[%0t] reply with nothing outstanding: %p", $time, got);
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.result_frame !== want.result_frame ||
                got.released_pages !== want.released_pages ||
                got.owners_after !== want.owners_after)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("[%0t] reply mismatch (expected/actual): status %0d/%0d, frame %0h/%0h, released %0d/%0d, owners %0d/%0d",
                             $time, want.status, got.status, want.result_frame,
                             got.result_frame, want.released_pages, got.released_pages,
                             want.owners_after, got.owners_after);
            end
        endfunction

        function int failures();
            return mismatches + pending_replies.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;

    frame_ledger ledger = new();
    bit          gaps_on;
    int          cycle_count;
    int          config_count;

    refcounted_page_frame_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_reply(rsp);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] run stopped after %0d cycles without finishing", $time, cycle_count);
        $display("refcounted_page_frame_allocator_core regression: fail");
        $finish;
    end

    task automatic send(input logic [1:0] f, input int count, input logic [20:0] frame);
        cmd_t c;
        c.func = f;
        c.page_count = 11'(count);
        c.frame_number = frame;
        while (gaps_on && $urandom_range(0, 99) < 22)
            @(negedge clk);
        @(negedge clk);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ledger.apply_request(c);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic write_regs(input logic [19:0] b, input logic [10:0] t,
                              input logic [10:0] r);
        logic [19:0] vals [3];
        logic [1:0]  regs [3];
        vals[0] = b;
        vals[1] = 20'(t);
        vals[2] = 20'(r);
        regs[0] = CFG_BASE;
        regs[1] = CFG_TOTAL;
        regs[2] = CFG_RESV;
        while (ledger.pending_replies.size() != 0 || busy)
            @(negedge clk);
        for (int k = 0; k < 3; k++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data <= vals[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            ledger.write_reg(regs[k], vals[k]);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        config_count++;
    endtask

    task automatic random_config();
        logic [19:0] b;
        logic [10:0] t;
        logic [10:0] r;
        int pct;
        case ($urandom_range(0, 3))
            0:
            begin
                b = '0;
            end
            1:
            begin
                b = 20'hFFFFF;
            end
            default:
            begin
                b = 20'($urandom);
            end
        endcase
        pct = $urandom_range(0, 99);
        if (pct < 55)
            t = 11'd1024;
        else if (pct < 70)
            t = 11'($urandom_range(2, 64));
        else if (pct < 85)
            t = 11'($urandom_range(65, 1023));
        else if (pct < 93)
            t = 11'($urandom_range(1025, 2047));
        else
            t = 11'($urandom_range(0, 1));
        pct = $urandom_range(0, 99);
        if (pct < 60)
            r = 11'($urandom_range(0, 3));
        else if (pct < 85)
            r = 11'($urandom_range(4, 32));
        else if (pct < 95)
            r = 11'($urandom_range(33, 1023));
        else
            r = 11'd1024;
        write_regs(b, t, r);
    endtask

    function automatic logic [20:0] frame_of(int idx);
        return (idx < 0) ? 21'($urandom) : ledger.phys(idx);
    endfunction

    task automatic random_item();
        int pct;
        int idx;
        int n;
        logic [1:0] f;
        pct = $urandom_range(0, 99);
        f = ($urandom_range(0, 1) != 0) ? FN_FREE : FN_SHARE;
        if (pct < 30)
        begin
            n = $urandom_range(0, 99);
            if (n < 70)
                n = $urandom_range(1, 4);
            else if (n < 88)
                n = $urandom_range(5, 32);
            else if (n < 97)
                n = $urandom_range(33, 256);
            else
                n = $urandom_range(0, 2047);
            send(FN_ALLOC, n, 21'($urandom));
        end
        else if (pct < 78)
        begin
            idx = ledger.pick(pct < 55);
            if (idx < 0)
                idx = ledger.in_range_index();
            send((pct >= 55 && pct < 70) ? FN_SHARE : FN_FREE, $urandom, frame_of(idx));
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    send(FN_UNKNOWN, $urandom, 21'($urandom));
                end
                1:
                begin
                    send(f, $urandom, 21'($urandom));
                end
                2:
                begin
                    if (ledger.resv > 0)
                        send(f, $urandom, ledger.phys($urandom_range(0, ledger.resv - 1)));
                    else
                        send(f, $urandom, ledger.phys(0) - 21'd1);
                end
                3:
                begin
                    send(f, $urandom, ledger.phys(ledger.span() + $urandom_range(0, 3)));
                end
                4:
                begin
                    send(FN_ALLOC, 0, 21'($urandom));
                end
                default:
                begin
                    send(FN_ALLOC, $urandom_range(0, 2047), 21'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        int idx;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BASE;
        cfg_data = '0;
        gaps_on = 1'b1;
        config_count = 0;
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;

        send(FN_ALLOC, 0, 21'h1FFFFF);
        send(FN_UNKNOWN, 2047, 21'h1FFFFF);
        send(FN_ALLOC, 1, 0);
        send(FN_ALLOC, 3, 0);
        send(FN_SHARE, 0, 3);
        send(FN_SHARE, 0, 2);
        send(FN_FREE, 0, 2);
        send(FN_FREE, 0, 2);
        send(FN_FREE, 0, 3);
        send(FN_FREE, 2047, 0);
        send(FN_SHARE, 0, 1024);
        send(FN_SHARE, 0, 1);
        send(FN_ALLOC, 2047, 0);
        send(FN_ALLOC, 1022, 0);
        send(FN_FREE, 0, 2);
        send(FN_ALLOC, 1024, 0);

        write_regs(20'hFFFFF, 11'd2047, 11'd0);
        send(FN_ALLOC, 1, 0);
        send(FN_SHARE, 0, 21'h0FFFFE);
        send(FN_SHARE, 0, 21'h100000);
        send(FN_FREE, 0, 21'h1003FF);

        write_regs(20'h0, 11'd0, 11'd1024);
        send(FN_ALLOC, 1, 0);
        send(FN_SHARE, 0, 1);

        // A run at the top of the map, freed after the map is shrunk under it.
        write_regs(20'h0, 11'd1024, 11'd1020);
        send(FN_ALLOC, 4, 0);
        write_regs(20'h0, 11'd1022, 11'd1020);
        send(FN_FREE, 0, 1020);

        for (int phase = 0; phase < 6; phase++)
        begin
            random_config();
            gaps_on = (phase != 2);
            repeat (50)
                random_item();
            if (phase == 2)
            begin
                // Push one frame's owner count into saturation, then walk it back down.
                write_regs(20'($urandom), 11'd1024, 11'd0);
                send(FN_ALLOC, 1, 21'($urandom));
                idx = ledger.last_head;
                if (idx < 0)
                    idx = ledger.pick(1'b0);
                if (idx < 0)
                    idx = ledger.in_range_index();
                repeat (258)
                    send(FN_SHARE, $urandom, frame_of(idx));
                repeat (3)
                    send(FN_FREE, $urandom, frame_of(idx));
            end
        end

        while (ledger.pending_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("Covered %0d commands over %0d register settings: %0d grants, %0d no-space, %0d rejected.",
                 ledger.n_requests, config_count + 1, ledger.n_granted, ledger.n_nospace,
                 ledger.n_bad);
        $display("Frees released %0d pages, highest owner count %0d, %0d mismatches.",
                 ledger.n_released, ledger.peak_owners, ledger.mismatches);
        if (ledger.failures() == 0)
            $display("refcounted_page_frame_allocator_core regression: pass");
        else
            $display("refcounted_page_frame_allocator_core regression: fail");
        $finish;
    end

endmodule
